// ----- rtl/bam_pkg.sv -----
// ----------------------------------------------------------------------------
// Body aggregate merge package
// Payload types, divider request types and constants shared by the block.
// ----------------------------------------------------------------------------
package bam_pkg;

    // Mass code that stands for an infinite mass.
    localparam logic [31:0] MASS_INF = 32'hFFFF_FFFF;
    // Largest circle radius.
    localparam logic [30:0] R_MAX = 31'h7FFF_FFFF;
    // Quotient lengths of the two kinds of division.
    localparam logic [5:0] DIV_W_STEPS = 6'd31;
    localparam logic [5:0] DIV_Q_STEPS = 6'd33;
    // Rounding half for the weighted mean (weights are Q1.30).
    localparam logic [65:0] ROUND_HALF = 66'd1 << 29;

    // One input body.
    typedef struct packed {
        logic               start_new;
        logic        [31:0] body_mass;
        logic signed [31:0] body_pos_x;
        logic signed [31:0] body_pos_y;
        logic signed [31:0] body_vel_x;
        logic signed [31:0] body_vel_y;
        logic        [30:0] body_radius;
    } t_bam_in;

    // One result: the aggregate after the merge.
    typedef struct packed {
        logic        [31:0] sum_mass;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] mean_vel_x;
        logic signed [31:0] mean_vel_y;
        logic signed [31:0] circle_x;
        logic signed [31:0] circle_y;
        logic        [30:0] circle_r;
        logic               skipped;
    } t_bam_out;

    // Divider request: the high part of the dividend seeds the remainder,
    // the low part is shifted in MSB first, one quotient bit per cycle.
    typedef struct packed {
        logic [33:0] rem0;
        logic [32:0] low;
        logic [33:0] divisor;
        logic [5:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [32:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/bam_stream_if.sv -----
// ----------------------------------------------------------------------------
// Body aggregate merge stream interface
// Valid/ready channel that carries one payload per transfer.
// ----------------------------------------------------------------------------
interface bam_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bam_div.sv -----
// ----------------------------------------------------------------------------
// Body aggregate merge divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bam_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bam_pkg::t_div_req  i_req,
    output bam_pkg::t_div_rsp  o_rsp
);
    import bam_pkg::*;

    logic [33:0] r_rem;
    logic [32:0] r_low;
    logic [33:0] r_div;
    logic [32:0] r_quot;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [34:0] trial;
    logic        fits;
    logic [34:0] diff;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        trial = {r_rem, r_low[32]};
        fits  = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    // Step sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_req.rem0;
                r_low  <= i_req.low;
                r_div  <= i_req.divisor;
                r_quot <= '0;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? diff[33:0] : trial[33:0];
                r_low  <= {r_low[31:0], 1'b0};
                r_quot <= {r_quot[31:0], fits};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- rtl/body_aggregate_merge_top.sv -----
// ----------------------------------------------------------------------------
// Body aggregate merge
// Merges one circular body per transfer into a running mass aggregate and
// a growing enclosing circle.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one body per transfer; start_new clears the aggregate first.
//   o_out carries one result per body: the aggregate after that merge.
//   The block takes one body at a time. i_in.ready is high only while idle.
//   A skipped merge goes straight to the result. A merge with an infinite
//   mass needs no division; a weighted mass merge runs a 31-step weight
//   division and four multiply/accumulate pairs. With a circle in place a
//   32-step square root follows; a circle grown around a coincident center
//   needs nothing more, and any other grown circle two 33-step offset divisions.
//   The multiplier is shared; the divider gives one quotient bit per cycle.
//   The result sits in an output register, so a new body is taken while the
//   last result waits; a stalled receiver only holds the next result back.
//   Reset clears the aggregate, the circle and the handshake state.
// ----------------------------------------------------------------------------
module body_aggregate_merge_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bam_stream_if.sink   i_in,
    bam_stream_if.source o_out
);
    import bam_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MASS, ST_WDIV, ST_WMUL, ST_WACC, ST_CIRC, ST_SQX, ST_SQY,
        ST_SQRT, ST_CHECK, ST_QXMUL, ST_QXDIV, ST_QYMUL, ST_QYDIV, ST_CUPD,
        ST_DONE
    } t_state;

    t_state r_state;
    t_bam_in r_body;
    t_bam_out r_out;
    logic r_out_valid;

    logic        [31:0] r_mass;
    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic signed [31:0] r_cx, r_cy;
    logic        [30:0] r_cr;
    logic               r_has;
    logic               r_skip;

    logic [32:0] r_sum;
    logic [30:0] r_w;
    logic [1:0]  r_comp;
    logic [65:0] r_prod;
    logic        r_neg;

    logic [32:0] r_ax, r_ay;
    logic        r_dxneg, r_dyneg, r_shift;
    logic [30:0] r_sx, r_sy;
    logic [62:0] r_v, r_root, r_bit;
    logic [32:0] r_d;
    logic [30:0] r_nr, r_drmag;
    logic        r_drneg;
    logic signed [33:0] r_qx, r_qy;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     div_start;

    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;

    logic        agg_inf, body_inf, both_zero, finite_merge;
    logic signed [31:0] comp_a, comp_b;
    logic signed [32:0] comp_diff;
    logic [32:0] comp_mag;
    logic [65:0] delta_full;
    logic signed [33:0] comp_new;

    logic signed [32:0] dx, dy;
    logic [32:0] ax, ay;
    logic [62:0] sq_cand;
    logic [32:0] root_dist;
    logic [33:0] reach, span;
    logic signed [31:0] dr;
    logic signed [34:0] sum_x, sum_y;

    logic        load_out;

    // Floor of the mean of two signed words.
    function automatic logic signed [31:0] half_sum(
        input logic signed [31:0] a,
        input logic signed [31:0] b
    );
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return s[32:1];
    endfunction

    // Saturate a halved circle center sum to a signed word.
    function automatic logic signed [31:0] sat_half(input logic signed [34:0] s);
        logic signed [33:0] h;
        h = s[34:1];
        if (h > 34'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (h < -34'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return h[31:0];
    endfunction

    // Mass classification.
    always_comb begin
        agg_inf      = r_mass == MASS_INF;
        body_inf     = r_body.body_mass == MASS_INF;
        both_zero    = (r_mass == '0) && (r_body.body_mass == '0);
        finite_merge = !agg_inf && !body_inf && !both_zero;
    end

    // Component selection and weighted-mean arithmetic.
    always_comb begin
        case (r_comp)
            2'd0: begin
                comp_a = r_px;
                comp_b = r_body.body_pos_x;
            end
            2'd1: begin
                comp_a = r_py;
                comp_b = r_body.body_pos_y;
            end
            2'd2: begin
                comp_a = r_vx;
                comp_b = r_body.body_vel_x;
            end
            default: begin
                comp_a = r_vy;
                comp_b = r_body.body_vel_y;
            end
        endcase
        comp_diff  = {comp_b[31], comp_b} - {comp_a[31], comp_a};
        comp_mag   = comp_diff[32] ? 33'(-comp_diff) : 33'(comp_diff);
        delta_full = (r_prod + ROUND_HALF) >> 30;
        comp_new   = r_neg ? ({{2{comp_a[31]}}, comp_a} - signed'(delta_full[33:0]))
                           : ({{2{comp_a[31]}}, comp_a} + signed'(delta_full[33:0]));
    end

    // Circle geometry.
    always_comb begin
        dx        = {r_body.body_pos_x[31], r_body.body_pos_x} - {r_cx[31], r_cx};
        dy        = {r_body.body_pos_y[31], r_body.body_pos_y} - {r_cy[31], r_cy};
        ax        = dx[32] ? 33'(-dx) : 33'(dx);
        ay        = dy[32] ? 33'(-dy) : 33'(dy);
        sq_cand   = r_root + r_bit;
        root_dist = r_shift ? {r_root[31:0], 1'b0} : {1'b0, r_root[31:0]};
        reach     = {1'b0, root_dist} + {3'b0, r_body.body_radius};
        span      = reach + {3'b0, r_cr};
        dr        = signed'({1'b0, r_body.body_radius}) - signed'({1'b0, r_cr});
        sum_x     = {{3{r_body.body_pos_x[31]}}, r_body.body_pos_x}
                  + {{3{r_cx[31]}}, r_cx} + {r_qx[33], r_qx};
        sum_y     = {{3{r_body.body_pos_y[31]}}, r_body.body_pos_y}
                  + {{3{r_cy[31]}}, r_cy} + {r_qy[33], r_qy};
    end

    // Shared multiplier operand selection.
    always_comb begin
        case (r_state)
            ST_WMUL: begin
                mul_a = comp_mag;
                mul_b = {2'b0, r_w};
            end
            ST_SQX: begin
                mul_a = {2'b0, r_sx};
                mul_b = {2'b0, r_sx};
            end
            ST_SQY: begin
                mul_a = {2'b0, r_sy};
                mul_b = {2'b0, r_sy};
            end
            ST_QXMUL: begin
                mul_a = {2'b0, r_drmag};
                mul_b = r_ax;
            end
            default: begin
                mul_a = {2'b0, r_drmag};
                mul_b = r_ay;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Divider requests: the mass weight, then the two center offsets.
    always_comb begin
        if (r_state == ST_MASS) begin
            div_req.rem0    = {3'b0, r_body.body_mass[31:1]};
            div_req.low     = {r_body.body_mass[0], 32'b0};
            div_req.divisor = {2'b0, r_mass} + {2'b0, r_body.body_mass};
            div_req.steps   = DIV_W_STEPS;
        end else begin
            div_req.rem0    = {3'b0, mul_p[63:33]};
            div_req.low     = mul_p[32:0];
            div_req.divisor = {1'b0, r_d};
            div_req.steps   = DIV_Q_STEPS;
        end
        div_start = ((r_state == ST_MASS) && finite_merge)
                 || (r_state == ST_QXMUL) || (r_state == ST_QYMUL);
    end

    bam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // The finished result moves into the output register once it is free.
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    // Sequencer, aggregate state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_mass      <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_cr        <= '0;
            r_has       <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_body  <= i_in.data;
                        r_skip  <= 1'b0;
                        r_state <= ST_MASS;
                        if (i_in.data.start_new) begin
                            r_mass <= '0;
                            r_px   <= '0;
                            r_py   <= '0;
                            r_vx   <= '0;
                            r_vy   <= '0;
                            r_cx   <= '0;
                            r_cy   <= '0;
                            r_cr   <= '0;
                            r_has  <= 1'b0;
                        end
                    end
                end
                ST_MASS: begin
                    r_sum  <= {1'b0, r_mass} + {1'b0, r_body.body_mass};
                    r_comp <= '0;
                    if (agg_inf && !body_inf) begin
                        r_state <= ST_CIRC;
                    end else if (!agg_inf && body_inf) begin
                        r_mass  <= r_body.body_mass;
                        r_px    <= r_body.body_pos_x;
                        r_py    <= r_body.body_pos_y;
                        r_vx    <= r_body.body_vel_x;
                        r_vy    <= r_body.body_vel_y;
                        r_state <= ST_CIRC;
                    end else if (agg_inf && body_inf) begin
                        r_px    <= half_sum(r_px, r_body.body_pos_x);
                        r_py    <= half_sum(r_py, r_body.body_pos_y);
                        r_vx    <= half_sum(r_vx, r_body.body_vel_x);
                        r_vy    <= half_sum(r_vy, r_body.body_vel_y);
                        r_state <= ST_CIRC;
                    end else if (both_zero) begin
                        r_skip  <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_WDIV;
                    end
                end
                ST_WDIV: begin
                    if (div_rsp.done) begin
                        r_w     <= div_rsp.quot[30:0];
                        r_state <= ST_WMUL;
                    end
                end
                ST_WMUL: begin
                    r_prod  <= mul_p;
                    r_neg   <= comp_diff[32];
                    r_state <= ST_WACC;
                end
                ST_WACC: begin
                    case (r_comp)
                        2'd0:    r_px <= comp_new[31:0];
                        2'd1:    r_py <= comp_new[31:0];
                        2'd2:    r_vx <= comp_new[31:0];
                        default: r_vy <= comp_new[31:0];
                    endcase
                    r_comp <= r_comp + 2'd1;
                    if (r_comp == 2'd3) begin
                        r_mass  <= r_sum[32] ? MASS_INF : r_sum[31:0];
                        r_state <= ST_CIRC;
                    end else begin
                        r_state <= ST_WMUL;
                    end
                end
                ST_CIRC: begin
                    r_has <= 1'b1;
                    if (!r_has) begin
                        r_cx    <= r_body.body_pos_x;
                        r_cy    <= r_body.body_pos_y;
                        r_cr    <= r_body.body_radius;
                        r_state <= ST_DONE;
                    end else begin
                        r_ax    <= ax;
                        r_ay    <= ay;
                        r_dxneg <= dx[32];
                        r_dyneg <= dy[32];
                        r_shift <= ax[32] || ax[31] || ay[32] || ay[31];
                        r_sx    <= (ax[32] || ax[31] || ay[32] || ay[31])
                                   ? ax[31:1] : ax[30:0];
                        r_sy    <= (ax[32] || ax[31] || ay[32] || ay[31])
                                   ? ay[31:1] : ay[30:0];
                        r_state <= ST_SQX;
                    end
                end
                ST_SQX: begin
                    r_v     <= mul_p[62:0];
                    r_state <= ST_SQY;
                end
                ST_SQY: begin
                    r_v     <= r_v + mul_p[62:0];
                    r_root  <= '0;
                    r_bit   <= 63'd1 << 62;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    // One result bit per cycle, digit pairs from the top.
                    if (r_v >= sq_cand) begin
                        r_v    <= r_v - sq_cand;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_d     <= root_dist;
                    r_nr    <= span[33:32] != 2'b00 ? R_MAX : span[31:1];
                    r_drmag <= dr[31] ? 31'(-dr) : dr[30:0];
                    r_drneg <= dr[31];
                    r_qx    <= '0;
                    r_qy    <= '0;
                    if (reach <= {3'b0, r_cr}) begin
                        r_state <= ST_DONE;
                    end else if (root_dist == '0) begin
                        r_state <= ST_CUPD;
                    end else begin
                        r_state <= ST_QXMUL;
                    end
                end
                ST_QXMUL: begin
                    r_state <= ST_QXDIV;
                end
                ST_QXDIV: begin
                    if (div_rsp.done) begin
                        r_qx <= (r_drneg ^ r_dxneg) ? -signed'({1'b0, div_rsp.quot})
                                                    : signed'({1'b0, div_rsp.quot});
                        r_state <= ST_QYMUL;
                    end
                end
                ST_QYMUL: begin
                    r_state <= ST_QYDIV;
                end
                ST_QYDIV: begin
                    if (div_rsp.done) begin
                        r_qy <= (r_drneg ^ r_dyneg) ? -signed'({1'b0, div_rsp.quot})
                                                    : signed'({1'b0, div_rsp.quot});
                        r_state <= ST_CUPD;
                    end
                end
                ST_CUPD: begin
                    r_cx    <= sat_half(sum_x);
                    r_cy    <= sat_half(sum_y);
                    r_cr    <= r_nr;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // Load the result once the output register is free.
                    if (load_out) begin
                        r_out.sum_mass   <= r_mass;
                        r_out.center_x   <= r_px;
                        r_out.center_y   <= r_py;
                        r_out.mean_vel_x <= r_vx;
                        r_out.mean_vel_y <= r_vy;
                        r_out.circle_x   <= r_cx;
                        r_out.circle_y   <= r_cy;
                        r_out.circle_r   <= r_cr;
                        r_out.skipped    <= r_skip;
                        r_state          <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready  = r_state == ST_IDLE;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    // A body in work blocks the next transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken while a body is in work");

    // A skipped merge only happens on an empty aggregate.
    a_skip_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.skipped |-> o_out.data.sum_mass == '0)
        else $error("skipped result with a nonzero mass");

    // The divider finishes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_WDIV) || (r_state == ST_QXDIV)
                      || (r_state == ST_QYDIV))
        else $error("divider result arrived outside a wait state");
`endif

endmodule

// ----- dv/bam_merge_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Body aggregate merge checker
// Watches both channels, keeps its own copy of the aggregate and the
// enclosing circle, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module bam_merge_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  bam_pkg::t_bam_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  bam_pkg::t_bam_out i_out_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_results,
    output int                o_skips,
    output int                o_grows
);
    import bam_pkg::*;

    // Aggregate and circle state, held wide for the arithmetic.
    longint unsigned mass_acc;
    longint          pos_x, pos_y, vel_x, vel_y;
    longint          ring_x, ring_y, ring_r;
    bit              has_bodies;

    t_bam_out expected_results[$];

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint half_floor(longint v);
        return v >>> 1;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint weighted_mean(longint a, longint b, longint unsigned w);
        longint          diff;
        longint unsigned step;
        diff = b - a;
        step = (mag(diff) * w + (64'd1 << 29)) >> 30;
        return (diff < 0) ? a - longint'(step) : a + longint'(step);
    endfunction

    // Offset of the new center along one axis.
    function automatic longint center_shift(longint dr, longint dv, longint unsigned d);
        longint q;
        if (d == 0 || dr == 0 || dv == 0) return 0;
        q = longint'((mag(dr) * mag(dv)) / d);
        return ((dr < 0) != (dv < 0)) ? -q : q;
    endfunction

    // Grow the enclosing circle so that it holds the body.
    task automatic grow_ring(longint bx, longint by, longint rb);
        longint          dx, dy, dr, nx, ny;
        longint unsigned sx, sy, d, nr;
        if (!has_bodies) begin
            ring_x = bx;
            ring_y = by;
            ring_r = rb;
            return;
        end
        dx = bx - ring_x;
        dy = by - ring_y;
        sx = mag(dx);
        sy = mag(dy);
        if (sx >= 64'h8000_0000 || sy >= 64'h8000_0000) begin
            d = root_floor((sx >> 1) * (sx >> 1) + (sy >> 1) * (sy >> 1)) << 1;
        end else begin
            d = root_floor(sx * sx + sy * sy);
        end
        if (d + longint'(rb) <= longint'(ring_r)) return;
        o_grows++;
        nr = (d + rb + ring_r) >> 1;
        if (nr > 64'h7FFF_FFFF) nr = 64'h7FFF_FFFF;
        dr = rb - ring_r;
        nx = clamp32(half_floor(bx + ring_x + center_shift(dr, dx, d)));
        ny = clamp32(half_floor(by + ring_y + center_shift(dr, dy, d)));
        ring_x = nx;
        ring_y = ny;
        ring_r = longint'(nr);
    endtask

    task automatic clear_aggregate();
        mass_acc   = 0;
        pos_x      = 0;
        pos_y      = 0;
        vel_x      = 0;
        vel_y      = 0;
        ring_x     = 0;
        ring_y     = 0;
        ring_r     = 0;
        has_bodies = 0;
    endtask

    // Merge one body and queue the aggregate that results.
    task automatic merge_body(t_bam_in b);
        longint unsigned mb, s, w;
        longint          px, py, vx, vy;
        bit              agg_inf, body_inf, skip;
        t_bam_out        r;
        mb   = b.body_mass;
        px   = b.body_pos_x;
        py   = b.body_pos_y;
        vx   = b.body_vel_x;
        vy   = b.body_vel_y;
        skip = 0;
        if (b.start_new) clear_aggregate();
        agg_inf  = (mass_acc == MASS_INF);
        body_inf = (mb == MASS_INF);
        if (agg_inf && !body_inf) begin
            // An infinite aggregate keeps its kinematics.
        end else if (!agg_inf && body_inf) begin
            mass_acc = mb;
            pos_x    = px;
            pos_y    = py;
            vel_x    = vx;
            vel_y    = vy;
        end else if (agg_inf && body_inf) begin
            pos_x = half_floor(pos_x + px);
            pos_y = half_floor(pos_y + py);
            vel_x = half_floor(vel_x + vx);
            vel_y = half_floor(vel_y + vy);
        end else if (mass_acc == 0 && mb == 0) begin
            skip = 1;
        end else begin
            s        = mass_acc + mb;
            w        = (mb << 30) / s;
            pos_x    = weighted_mean(pos_x, px, w);
            pos_y    = weighted_mean(pos_y, py, w);
            vel_x    = weighted_mean(vel_x, vx, w);
            vel_y    = weighted_mean(vel_y, vy, w);
            mass_acc = (s > MASS_INF) ? longint'(MASS_INF) : s;
        end
        if (!skip) begin
            grow_ring(px, py, longint'(b.body_radius));
            has_bodies = 1;
        end else begin
            o_skips++;
        end
        r.sum_mass   = mass_acc[31:0];
        r.center_x   = pos_x[31:0];
        r.center_y   = pos_y[31:0];
        r.mean_vel_x = vel_x[31:0];
        r.mean_vel_y = vel_y[31:0];
        r.circle_x   = ring_x[31:0];
        r.circle_y   = ring_y[31:0];
        r.circle_r   = ring_r[30:0];
        r.skipped    = skip;
        expected_results = {expected_results, r};
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        o_errors++;
        $display("[%0t] result %0d: %s got %0h, expected %0h", $realtime, o_results, what,
                 got, want);
    endtask

    // Compare one result with the oldest expectation.
    task automatic check_result(t_bam_out got);
        t_bam_out want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.sum_mass !== want.sum_mass)
            report_mismatch("sum_mass", got.sum_mass, want.sum_mass);
        if (got.center_x !== want.center_x)
            report_mismatch("center_x", got.center_x, want.center_x);
        if (got.center_y !== want.center_y)
            report_mismatch("center_y", got.center_y, want.center_y);
        if (got.mean_vel_x !== want.mean_vel_x)
            report_mismatch("mean_vel_x", got.mean_vel_x, want.mean_vel_x);
        if (got.mean_vel_y !== want.mean_vel_y)
            report_mismatch("mean_vel_y", got.mean_vel_y, want.mean_vel_y);
        if (got.circle_x !== want.circle_x)
            report_mismatch("circle_x", got.circle_x, want.circle_x);
        if (got.circle_y !== want.circle_y)
            report_mismatch("circle_y", got.circle_y, want.circle_y);
        if (got.circle_r !== want.circle_r)
            report_mismatch("circle_r", got.circle_r, want.circle_r);
        if (got.skipped !== want.skipped)
            report_mismatch("skipped", got.skipped, want.skipped);
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
        o_skips   = 0;
        o_grows   = 0;
        clear_aggregate();
    end

    assign o_pending = expected_results.size();

    // Sample both channels at the edge; the stimulus changes after it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_aggregate();
        end else begin
            if (i_in_valid && i_in_ready) merge_body(i_in_data);
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
                o_results++;
            end
        end
    end

endmodule

// ----- dv/tb_body_aggregate_merge_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Body aggregate merge testbench
// Drives directed and random bodies through the merge block with random
// idling on both channels, and lets the checker predict and compare.
// ----------------------------------------------------------------------------
module tb_body_aggregate_merge_top;
    import bam_pkg::*;

    localparam int RANDOM_BODIES = 780;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 300;

    logic i_clk;
    logic i_rst_n;

    bam_stream_if #(.t_payload(t_bam_in))  body_ch ();
    bam_stream_if #(.t_payload(t_bam_out)) result_ch ();

    int errors, pending, results, skips, grows;
    int send_idle_pct, recv_idle_pct;
    bit hold_receiver;
    int quiet_cycles;
    int sent;

    t_bam_in directed[$];

    body_aggregate_merge_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (body_ch),
        .o_out  (result_ch)
    );

    bam_merge_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (body_ch.valid),
        .i_in_ready (body_ch.ready),
        .i_in_data  (body_ch.data),
        .i_out_valid(result_ch.valid),
        .i_out_ready(result_ch.ready),
        .i_out_data (result_ch.data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results),
        .o_skips    (skips),
        .o_grows    (grows)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Receiver: random ready, or held low during a long hold-off.
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_receiver)
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (body_ch.valid && body_ch.ready) ||
            (result_ch.valid && result_ch.ready) || hold_receiver) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("body_aggregate_merge_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one body and wait for its transfer, with random idle cycles first.
    task automatic send_body(t_bam_in b);
        while ($urandom_range(99) < send_idle_pct) begin
            body_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        body_ch.valid <= 1'b1;
        body_ch.data  <= b;
        @(posedge i_clk);
        while (!body_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    // Append one body to the directed list.
    task automatic add_directed(t_bam_in b);
        directed = {directed, b};
    endtask

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return MASS_INF;
            2:       return 32'hFFFF_FFFE - $urandom_range(3);
            3, 4:    return $urandom();
            default: return $urandom_range(32'h0008_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(7))
            0:       return 32'h8000_0000 + $urandom_range(3);
            1:       return 32'h7FFF_FFFF - $urandom_range(3);
            2:       return $urandom();
            default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    function automatic t_bam_in random_body(bit first);
        t_bam_in b;
        b.start_new   = first || ($urandom_range(19) == 0);
        b.body_mass   = pick_mass();
        b.body_pos_x  = pick_coord();
        b.body_pos_y  = pick_coord();
        b.body_vel_x  = pick_coord();
        b.body_vel_y  = pick_coord();
        case ($urandom_range(5))
            0:       b.body_radius = 31'(32'h7FFF_FFFF - $urandom_range(3));
            1:       b.body_radius = '0;
            2:       b.body_radius = 31'($urandom());
            default: b.body_radius = 31'($urandom_range(32'h0010_0000));
        endcase
        return b;
    endfunction

    function automatic t_bam_in make_body(bit sn, logic [31:0] m, logic [31:0] x,
                                          logic [31:0] y, logic [30:0] r);
        t_bam_in b;
        b.start_new   = sn;
        b.body_mass   = m;
        b.body_pos_x  = x;
        b.body_pos_y  = y;
        b.body_vel_x  = ~x;
        b.body_vel_y  = y ^ 32'h5555_5555;
        b.body_radius = r;
        return b;
    endfunction

    task automatic wait_drained();
        body_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int hold_len;
        body_ch.valid  = 1'b0;
        body_ch.data   = '0;
        i_rst_n        = 1'b0;
        hold_receiver  = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        quiet_cycles   = 0;
        sent           = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero masses, infinite masses, saturation, zero distance,
        // enclosed bodies, extreme coordinates and radii.
        add_directed(make_body(0, 32'h0, 32'h1000, 32'h2000, 31'h100));
        add_directed(make_body(0, 32'h0001_0000, 32'h0, 32'h0, 31'h0));
        add_directed(make_body(0, 32'h0001_0000, 32'h0, 32'h0, 31'h0));
        add_directed(make_body(0, 32'h0002_0000, 32'h0, 32'h0, 31'h4000));
        add_directed(make_body(0, 32'h0000_0100, 32'h0, 32'h100, 31'h10));
        add_directed(make_body(0, 32'h0, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
        add_directed(make_body(0, MASS_INF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h1));
        add_directed(make_body(0, 32'h1234, 32'h8000_0000, 32'h0, 31'h0));
        add_directed(make_body(0, MASS_INF, 32'h8000_0000, 32'h8000_0001, 31'h0));
        add_directed(make_body(1, MASS_INF, 32'hFFFF_FFFF, 32'h1, 31'h2));
        add_directed(make_body(1, 32'h0, 32'h0, 32'h0, 31'h0));
        add_directed(make_body(0, 32'h0, 32'h0, 32'h0, 31'h0));
        add_directed(make_body(1, 32'hFFFF_FFF0, 32'h7FFF_FFFF, 32'h8000_0000,
                               31'h7FFF_FFFF));
        add_directed(make_body(0, 32'hFFFF_FFF0, 32'h8000_0000, 32'h7FFF_FFFF,
                               31'h7FFF_FFFF));
        add_directed(make_body(1, 32'h1, 32'h10000, 32'h0, 31'h10000));
        add_directed(make_body(0, 32'h1, 32'hFFFF_0000, 32'h0, 31'h30000));
        add_directed(make_body(0, 32'h1, 32'h0, 32'h7FFF_FFFF, 31'h5));
        send_idle_pct = 33;
        recv_idle_pct = 62;
        foreach (directed[i]) send_body(directed[i]);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering bodies.
        hold_receiver <= 1'b1;
        send_idle_pct = 0;
        fork
            begin
                hold_len = 600;
                repeat (hold_len) @(posedge i_clk);
                hold_receiver <= 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++) send_body(random_body(i == 0));
            end
        join
        wait_drained();

        // Random phases with changing idle rates.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 33 : 0;
            for (int i = 0; i < RANDOM_BODIES / 3; i++) begin
                send_body(random_body(i == 0));
                if ($urandom_range(49) == 0) wait_drained();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d bodies, checked %0d results: %0d skipped merges, %0d circle growths.",
                 sent, results, skips, grows);
        $display("Idling covered sender-heavy, receiver-heavy and back-to-back phases.");
        if (errors == 0 && pending == 0) begin
            $display("body_aggregate_merge_top regression: pass");
        end else begin
            $display("body_aggregate_merge_top regression: fail");
        end
        $finish;
    end

endmodule
